// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the tape pulse decoder.
// Needs nothing else; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/core/tpbs_pkg.sv -----
// Package for the tape pulse bit and sync decoder: types, constants and
// the per-bit framing function. Depends on nothing.
`timescale 1ns / 1ps

package tpbs_pkg;

  localparam int unsigned PULSE_BITS = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CMP_W      = (PULSE_BITS > LIMIT_W) ? PULSE_BITS : LIMIT_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PILOT_VALUE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PILOT_RUN = 2'd3;

  // Reset values
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 16'd422;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 16'd600;
  localparam logic [7:0]         PILOT_VALUE_RST   = 8'h55;
  localparam logic [7:0]         MIN_PILOT_RUN_RST = 8'h08;

  // Hunting byte that forces the bit machine back to its second phase
  localparam logic [7:0] FORCE_VALUE = 8'h3f;
  localparam logic [7:0] PILOT_MAX   = 8'hff;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_NEXT0  = 2'd2,
    PH_NEXT1  = 2'd3
  } bit_phase_e;

  typedef enum logic [1:0] {
    FR_HUNT  = 2'd0,
    FR_COUNT = 2'd1,
    FR_DATA  = 2'd2
  } frame_e;

  localparam logic KIND_SYNC = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic [LIMIT_W-1:0] short_limit;
    logic [LIMIT_W-1:0] long_limit;
    logic [7:0]         pilot_value;
    logic [7:0]         min_pilot_run;
  } cfg_t;

  typedef struct packed {
    bit_phase_e phase;
    logic [7:0] shift_byte;
    logic [2:0] bit_count;
    frame_e     frame;
    logic [7:0] pilot_cnt;
    logic [7:0] checksum;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_kind;
    logic [7:0] running_sum;
    logic [7:0] pilot_run;
  } result_t;

  typedef struct packed {
    state_t  st;
    logic    emit;
    result_t res;
  } take_t;

  localparam state_t STATE_RST = '{
    phase:      PH_SECOND,
    shift_byte: 8'h00,
    bit_count:  3'd0,
    frame:      FR_HUNT,
    pilot_cnt:  8'h00,
    checksum:   8'h00
  };

  // Shift one bit into the byte and advance the framing logic.
  function automatic take_t take_bit(state_t s, logic b, cfg_t c);
    take_t      t;
    logic [7:0] sh;
    logic [2:0] bc;
    logic [7:0] sum;
    t      = '0;
    t.st   = s;
    sh     = {s.shift_byte[6:0], b};
    bc     = s.bit_count + 3'd1;
    sum    = s.checksum + sh + 8'd1;
    t.st.shift_byte = sh;
    if (s.frame == FR_HUNT) begin
      if (sh == FORCE_VALUE) begin
        t.st.phase = PH_SECOND;
      end
      if (sh == c.pilot_value) begin
        t.st.frame     = FR_COUNT;
        t.st.pilot_cnt = 8'd1;
        t.st.bit_count = 3'd0;
      end
    end else begin
      t.st.bit_count = bc;
      if (bc == 3'd0) begin
        if (s.frame == FR_COUNT) begin
          if (sh == c.pilot_value) begin
            if (s.pilot_cnt != PILOT_MAX) begin
              t.st.pilot_cnt = s.pilot_cnt + 8'd1;
            end
          end else if (s.pilot_cnt < c.min_pilot_run) begin
            // run too short: keep hunting from this byte
            t.st.frame = FR_HUNT;
          end else begin
            t.st.frame    = FR_DATA;
            t.st.checksum = 8'h00;
            t.emit        = 1'b1;
            t.res         = '{byte_value: sh, byte_kind: KIND_SYNC,
                              running_sum: 8'h00, pilot_run: s.pilot_cnt};
          end
        end else begin
          t.st.checksum = sum;
          t.emit        = 1'b1;
          t.res         = '{byte_value: sh, byte_kind: KIND_DATA,
                            running_sum: sum, pilot_run: s.pilot_cnt};
        end
      end
    end
    return t;
  endfunction

endpackage

// ----- rtl/core/tpbs_step.sv -----
// Per-pulse decode: classification, bit machine and framing of up to two bits.
// Depends on tpbs_pkg.
`timescale 1ns / 1ps

module tpbs_step (
  input  tpbs_pkg::state_t                 state_i,
  input  tpbs_pkg::cfg_t                   cfg_i,
  input  logic [tpbs_pkg::PULSE_BITS-1:0]  pulse_length_i,
  input  logic                             restart_i,
  output tpbs_pkg::state_t                 state_o,
  output logic                             emit_o,
  output tpbs_pkg::result_t                result_o
);

  tpbs_pkg::state_t s0;
  tpbs_pkg::state_t s1;
  tpbs_pkg::state_t s2;
  tpbs_pkg::take_t  t1;
  tpbs_pkg::take_t  t2;
  logic [tpbs_pkg::CMP_W-1:0] len;
  logic is_short;
  logic is_long;
  logic b1;
  logic b2;
  logic second;

  // Restart clears the frame before this pulse is looked at
  assign s0  = restart_i ? tpbs_pkg::STATE_RST : state_i;

  // Short test first, so crossed limits still give short
  assign len      = tpbs_pkg::CMP_W'(pulse_length_i);
  assign is_short = len < tpbs_pkg::CMP_W'(cfg_i.short_limit);
  assign is_long  = !is_short && (len >= tpbs_pkg::CMP_W'(cfg_i.long_limit));

  // First bit of the pulse
  always_comb begin
    s1 = s0;
    if (s0.phase == tpbs_pkg::PH_FIRST) begin
      b1 = is_short;
      if (!is_short) begin
        s1.phase = is_long ? tpbs_pkg::PH_NEXT1 : tpbs_pkg::PH_NEXT0;
      end
    end else begin
      b1 = !is_short;
      if (!is_short) begin
        s1.phase = tpbs_pkg::PH_FIRST;
      end
    end
  end

  assign t1 = tpbs_pkg::take_bit(s1, b1, cfg_i);

  // Pending second bit, unless the force value dropped it
  assign second = (t1.st.phase == tpbs_pkg::PH_NEXT0) ||
                  (t1.st.phase == tpbs_pkg::PH_NEXT1);
  assign b2     = (t1.st.phase == tpbs_pkg::PH_NEXT1);

  always_comb begin
    s2       = t1.st;
    s2.phase = b2 ? tpbs_pkg::PH_FIRST : tpbs_pkg::PH_SECOND;
  end

  assign t2 = tpbs_pkg::take_bit(s2, b2, cfg_i);

  // Only one byte per pulse leaves; a second one is absorbed
  assign state_o  = second ? t2.st : t1.st;
  assign emit_o   = t1.emit || (second && t2.emit);
  assign result_o = t1.emit ? t1.res : t2.res;

endmodule

// ----- rtl/core/tpbs_out_buf.sv -----
// Two-entry result buffer between the decoder and the output channel.
// Depends on tpbs_pkg.
`timescale 1ns / 1ps

module tpbs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpbs_pkg::result_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output tpbs_pkg::result_t data_o
);

  tpbs_pkg::result_t buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = buf_q[rd_ptr_q];

endmodule

// ----- rtl/core/tape_pulse_bit_sync_decoder_core.sv -----
// Top level of the tape pulse bit and sync decoder.
// Depends on tpbs_pkg, tpbs_step, tpbs_out_buf and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// - Input channel: one transaction per measured pulse (pulse_length_i,
//   restart_i), taken when in_valid_i is high and in_stall_o is low.
// - Output channel: one transaction per emitted byte (sync or data), taken
//   when out_valid_o is high and out_stall_i is low.
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (short limit, long limit, pilot value, minimum pilot run); write only
//   while the block is idle.
// - Throughput: one pulse per cycle while in_stall_o is low. The whole pulse
//   (classification, both bits of the bit machine, framing) is decoded
//   combinationally; the frame state registers update at the accepting edge.
// - Output path: a byte caused by a pulse is written into the result buffer at
//   the accepting edge and is shown once the bytes ahead of it are taken.
// - A two-entry result buffer parts the channels: while the receiver stalls,
//   pulses keep being taken until the buffer holds two bytes; then
//   in_stall_o stays high until a byte is taken.
// - Reset clears the frame state (hunting, bit machine in its second
//   phase), empties the result buffer and loads the default register values.
module tape_pulse_bit_sync_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [tpbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpbs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pulse input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tpbs_pkg::PULSE_BITS-1:0]    pulse_length_i,
  input  logic                               restart_i,
  // byte output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         byte_value_o,
  output logic                               byte_kind_o,
  output logic [7:0]                         running_sum_o,
  output logic [7:0]                         pilot_run_o
);

  tpbs_pkg::cfg_t    cfg_q, cfg_d;
  tpbs_pkg::state_t  state_q;
  tpbs_pkg::state_t  state_nxt;
  tpbs_pkg::result_t step_res;
  tpbs_pkg::result_t out_res;
  logic              step_emit;
  logic              in_acc;
  logic              out_acc;
  logic              buf_full;
  logic              pend_bit;
  logic              frame_data;
  logic              frame_hunt;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tpbs_pkg::CFG_SHORT_LIMIT:   cfg_d.short_limit   = cfg_data_i;
        tpbs_pkg::CFG_LONG_LIMIT:    cfg_d.long_limit    = cfg_data_i;
        tpbs_pkg::CFG_PILOT_VALUE:   cfg_d.pilot_value   = cfg_data_i[7:0];
        tpbs_pkg::CFG_MIN_PILOT_RUN: cfg_d.min_pilot_run = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit   <= tpbs_pkg::SHORT_LIMIT_RST;
      cfg_q.long_limit    <= tpbs_pkg::LONG_LIMIT_RST;
      cfg_q.pilot_value   <= tpbs_pkg::PILOT_VALUE_RST;
      cfg_q.min_pilot_run <= tpbs_pkg::MIN_PILOT_RUN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pulse decode
  tpbs_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .pulse_length_i (pulse_length_i),
    .restart_i      (restart_i),
    .state_o        (state_nxt),
    .emit_o         (step_emit),
    .result_o       (step_res)
  );

  // Frame state advances on each accepted pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpbs_pkg::STATE_RST;
    end else if (in_acc) begin
      state_q <= state_nxt;
    end
  end

  // Result buffer
  tpbs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && step_emit),
    .push_data_i (step_res),
    .pop_i       (out_acc),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .data_o      (out_res)
  );

  assign in_stall_o    = buf_full;
  assign byte_value_o  = out_res.byte_value;
  assign byte_kind_o   = out_res.byte_kind;
  assign running_sum_o = out_res.running_sum;
  assign pilot_run_o   = out_res.pilot_run;

  // Checks
  assign pend_bit   = (state_q.phase == tpbs_pkg::PH_NEXT0) ||
                      (state_q.phase == tpbs_pkg::PH_NEXT1);
  assign frame_data = (state_q.frame == tpbs_pkg::FR_DATA);
  assign frame_hunt = (state_q.frame == tpbs_pkg::FR_HUNT);

  `ASSERT_PROP(a_full_has_output, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  `ASSERT_NEVER(a_no_pending_bit, clk_i, rst_ni, pend_bit)
  `ASSERT_PROP(a_sum_only_in_data, clk_i, rst_ni, !frame_data |-> (state_q.checksum == 8'h00))
  `ASSERT_PROP(a_count_nonzero, clk_i, rst_ni, !frame_hunt |-> (state_q.pilot_cnt != 8'h00))

endmodule
